// ===== hw/rtl/nmu_pkg.sv =====
package nmu_pkg;

  // field widths
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int COEF_W = 16;
  localparam int FRAC_W = 16;

  // velocity store, one entry per weight element
  // element index maps to an entry by its low bits (store depth is a power of two)
  localparam int ELEMENTS = 1024;
  localparam int SLOT_W   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  // product and accumulator widths
  localparam int PROD_W = VAL_W + COEF_W + 1;   // 17 x 32 signed
  localparam int ACC_W  = PROD_W + 3;           // sum of shifted weight and two products

  // stream packing
  localparam int FIELDS_W = IDX_W + 2 * VAL_W;
  localparam int DATA_W   = ((FIELDS_W + 7) / 8) * 8;

  // result queue that decouples the pipeline from the output handshake
  localparam int OUT_DEPTH = 8;
  localparam int PTR_W     = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM  = 1'd1;
  localparam logic [COEF_W-1:0] STEP_RATE_RST = 16'd655;
  localparam logic [COEF_W-1:0] MOMENTUM_RST  = 16'd58982;

  // 1.0 in unsigned Q0.16 needs one more bit
  localparam logic [COEF_W:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [COEF_W-1:0] step_rate;
    logic [COEF_W-1:0] momentum;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] weight;
    logic signed [VAL_W-1:0] gradient;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] weight;
    logic signed [VAL_W-1:0] velocity;
  } res_t;

  // Q20.32 -> Q16.16: add half an lsb, floor, then clamp to 32 bits
  function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0]        t;
    logic signed [ACC_W-FRAC_W-1:0] q;
    t = x + ACC_W'(2 ** (FRAC_W - 1));
    q = t[ACC_W-1:FRAC_W];
    if ((&q[ACC_W-FRAC_W-1:VAL_W-1]) || !(|q[ACC_W-FRAC_W-1:VAL_W-1])) begin
      return q[VAL_W-1:0];
    end
    if (q[ACC_W-FRAC_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end
    return {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

endpackage

// ===== hw/rtl/nmu_ram.sv =====
module nmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/nmu_update_pipe.sv =====
module nmu_update_pipe (
  input  logic          clk,
  input  logic          rst_n,
  input  nmu_pkg::cfg_t  cfg,
  input  logic          space_ok,
  input  logic          in_valid,
  output logic          in_ready,
  input  nmu_pkg::item_t in_item,
  output logic          res_valid,
  output nmu_pkg::res_t  res
);
  import nmu_pkg::*;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    return idx[SLOT_W-1:0];
  endfunction

  // stage valids and clear sweep
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r;
  logic v0_nxt;
  logic clr_busy_r;
  logic [SLOT_W-1:0] clr_addr_r;

  // stage payloads
  item_t s0_r, s1_r, s2_r;
  logic signed [VAL_W-1:0]  vold2_r;
  logic [IDX_W-1:0]         idx3_r, idx4_r, idx5_r;
  logic signed [VAL_W-1:0]  w3_r, w4_r, w5_r;
  logic signed [PROD_W-1:0] mv3_r, rg3_r, mv4_r, mv5_r;
  logic signed [VAL_W-1:0]  vnew4_r, vnew5_r;
  logic signed [PROD_W:0]   p5_r;

  logic hazard, adv0, load0;
  logic signed [VAL_W-1:0]  vold1;
  logic signed [PROD_W-1:0] mv2, rg2;
  logic signed [ACC_W-1:0]  vsum3, acc5;
  logic signed [VAL_W-1:0]  vnew3;
  logic [COEF_W:0]          coef4;
  logic signed [PROD_W:0]   p4;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  // an entry read right after the item ahead read it would miss that item's
  // write and its forward, so the newer one is held back in stage 0
  always_comb begin
    hazard   = v0_r && v1_r && (slot_of(s0_r.idx) == slot_of(s1_r.idx));
    adv0     = v0_r && !hazard;
    in_ready = !clr_busy_r && space_ok && (!v0_r || !hazard);
    load0    = in_valid && in_ready;
    v0_nxt   = load0 || (v0_r && hazard);
  end

  assign ram_raddr = slot_of(s0_r.idx);

  // velocity forward: stage 3 is being written now, stage 4 was written
  // on the edge that issued this read
  always_comb begin
    vold1 = ram_rdata;
    if (v4_r && (slot_of(idx4_r) == slot_of(s1_r.idx))) begin
      vold1 = vnew4_r;
    end
    if (v3_r && (slot_of(idx3_r) == slot_of(s1_r.idx))) begin
      vold1 = vnew3;
    end
  end

  always_comb begin
    mv2   = $signed({1'b0, cfg.momentum}) * vold2_r;
    rg2   = $signed({1'b0, cfg.step_rate}) * s2_r.gradient;
    vsum3 = ACC_W'(mv3_r) - ACC_W'(rg3_r);
    vnew3 = round_sat(vsum3);
    coef4 = ONE_Q16 + {1'b0, cfg.momentum};
    p4    = $signed({1'b0, coef4}) * vnew4_r;
    acc5  = (ACC_W'(w5_r) <<< FRAC_W) + ACC_W'(p5_r) - ACC_W'(mv5_r);
  end

  always_comb begin
    ram_we    = clr_busy_r || v3_r;
    ram_waddr = clr_busy_r ? clr_addr_r : slot_of(idx3_r);
    ram_wdata = clr_busy_r ? '0 : vnew3;
  end

  nmu_ram #(
    .WIDTH(VAL_W),
    .DEPTH(ELEMENTS)
  ) u_vel_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r       <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= adv0;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (clr_busy_r) begin
        if (clr_addr_r == SLOT_W'(ELEMENTS - 1)) begin
          clr_busy_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load0) begin
      s0_r <= in_item;
    end
    s1_r    <= s0_r;
    s2_r    <= s1_r;
    vold2_r <= vold1;
    idx3_r  <= s2_r.idx;
    w3_r    <= s2_r.weight;
    mv3_r   <= mv2;
    rg3_r   <= rg2;
    idx4_r  <= idx3_r;
    w4_r    <= w3_r;
    mv4_r   <= mv3_r;
    vnew4_r <= vnew3;
    idx5_r  <= idx4_r;
    w5_r    <= w4_r;
    mv5_r   <= mv4_r;
    vnew5_r <= vnew4_r;
    p5_r    <= p4;
  end

  always_comb begin
    res_valid    = v5_r;
    res.idx      = idx5_r;
    res.weight   = round_sat(acc5);
    res.velocity = vnew5_r;
  end

endmodule

// ===== hw/rtl/nmu_out_fifo.sv =====
module nmu_out_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  nmu_pkg::res_t push_data,
  input  logic         pop_ready,
  output logic         out_valid,
  output nmu_pkg::res_t out_data
);
  import nmu_pkg::*;

  res_t             fifo_r [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // no full check: the top level only admits items that have a slot here
  assign out_valid = (count_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign pop       = out_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/nesterov_momentum_update_top.sv =====
// Nesterov momentum update, one weight element per input transaction. Each
// transaction carries an element index, the current weight and its gradient
// (signed Q16.16); the block looks up that element's stored velocity, forms
// v_new = momentum*v - rate*grad and w_new = w + (1+momentum)*v_new - momentum*v,
// rounds each to nearest (ties up), saturates to 32 bits, stores v_new and
// returns index, w_new and v_new. Rate and momentum are unsigned Q0.16 and may
// only be written while no transaction is in flight. Throughput is one
// transaction per clock unless a repeated index, the memory clear or a full queue
// stalls the input; results pass six pipeline stages and the output queue. The
// velocity recurrence closes through a multiplier, so a transaction whose element
// index equals that of the one accepted just before it is held in stage 0 until
// that one leaves stage 1; any larger spacing is covered by forwarding. After
// reset the block zeroes its 1024-entry velocity memory one entry per cycle,
// taking no input meanwhile. An 8-entry result queue lets input continue while
// out_tready is low, until the queue and pipeline together hold 8 results.
module nesterov_momentum_update_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // element_index, weight_in, gradient_in, zero pad
  input  logic [nmu_pkg::DATA_W-1:0]      in_tdata,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // element_index_out, weight_out, velocity_out, zero pad
  output logic [nmu_pkg::DATA_W-1:0]      out_tdata,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [nmu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nmu_pkg::COEF_W-1:0]      cfg_wdata
);
  import nmu_pkg::*;

  logic [COEF_W-1:0] step_rate_r, momentum_r;
  cfg_t              cfg;

  // results in flight or waiting in the queue
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic              space_ok;
  logic              in_xact, out_xact;

  item_t in_item;
  logic  pipe_ready;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_rate_r <= STEP_RATE_RST;
      momentum_r  <= MOMENTUM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_RATE: step_rate_r <= cfg_wdata;
        CFG_MOMENTUM:  momentum_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.step_rate = step_rate_r;
  assign cfg.momentum  = momentum_r;

  // unpack the input transaction
  assign in_item.idx      = in_tdata[IDX_W-1:0];
  assign in_item.weight   = in_tdata[IDX_W +: VAL_W];
  assign in_item.gradient = in_tdata[IDX_W + VAL_W +: VAL_W];

  // credit count: an item is only taken when its result has a queue slot
  assign in_tready = pipe_ready;
  assign in_xact   = in_tvalid && in_tready;
  assign out_xact  = out_tvalid && out_tready;
  assign space_ok  = (used_r < CNT_W'(OUT_DEPTH));
  assign used_nxt  = used_r + CNT_W'(in_xact) - CNT_W'(out_xact);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  nmu_update_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .space_ok (space_ok),
    .in_valid (in_tvalid),
    .in_ready (pipe_ready),
    .in_item  (in_item),
    .res_valid(res_valid),
    .res      (res)
  );

  nmu_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .pop_ready(out_tready),
    .out_valid(out_tvalid),
    .out_data (out_res)
  );

  // pack the result transaction
  assign out_tdata = {{(DATA_W - FIELDS_W){1'b0}},
                      out_res.velocity, out_res.weight, out_res.idx};

endmodule

// ===== hw/rtl/nmu_checker.sv =====
module nmu_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [nmu_pkg::DATA_W-1:0]      out_tdata
);
  import nmu_pkg::*;

  // transactions taken in but not yet returned
  logic [CNT_W:0] pend_r;
  logic           in_xact, out_xact;

  assign in_xact  = in_tvalid && in_tready;
  assign out_xact = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + (CNT_W + 1)'(in_xact) - (CNT_W + 1)'(out_xact);
    end
  end

  // reset empties the queue and starts the memory clear
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("output or input active right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_xact |-> (pend_r != '0))
    else $error("result without a pending input");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= (CNT_W + 1)'(OUT_DEPTH))
    else $error("more pending results than queue slots");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DATA_W-1:FIELDS_W] == '0))
    else $error("nonzero pad bits in result");

endmodule

bind nesterov_momentum_update_top nmu_checker u_nmu_checker (.*);

// ===== bench/nesterov_momentum_update_top_tb.sv =====
module nesterov_momentum_update_top_tb;
  import nmu_pkg::*;

  // bit positions of the packed fields, lowest first
  localparam int IDX_LO = 0;
  localparam int WGT_LO = IDX_W;
  localparam int SEC_LO = IDX_W + VAL_W;   // gradient on input, velocity on output

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] weight;
    logic signed [VAL_W-1:0] velocity;
  } update_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COEF_W-1:0]     cfg_wdata = '0;

  // shadow of the block: its velocity memory and its two coefficients
  logic signed [VAL_W-1:0] velocity_mem [ELEMENTS];
  logic [COEF_W-1:0]       rate_q16 = STEP_RATE_RST;
  logic [COEF_W-1:0]       mom_q16 = MOMENTUM_RST;

  // updates predicted at input acceptance, oldest first
  update_t pending_updates [$];
  int      fail_count = 0;

  // random idling control; a quiet stretch keeps that side from ever idling
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;
  logic [IDX_W-1:0] last_idx = '0;

  nesterov_momentum_update_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // generous fixed limit; a correct run needs a small fraction of this
  initial begin
    #400000;
    $display("[nesterov_momentum_update_top] ERROR");
    $finish;
  end

  // clamp a wide signed value into the 32-bit range
  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // one optimizer step on the shadow state: q32.32 sums, one rounding each
  // (add half an lsb, arithmetic shift), saturation, then store the new velocity
  function automatic update_t nesterov_step(input logic [IDX_W-1:0] idx,
                                            input logic signed [VAL_W-1:0] w,
                                            input logic signed [VAL_W-1:0] g);
    update_t r;
    longint  m, rt, vo, vn, wl, gl, acc, wn;
    m  = longint'(mom_q16);
    rt = longint'(rate_q16);
    vo = longint'(velocity_mem[idx % ELEMENTS]);
    wl = longint'(w);
    gl = longint'(g);
    vn  = clamp32((m * vo - rt * gl + 64'sd32768) >>> FRAC_W);
    acc = wl * 64'sd65536 + (64'sd65536 + m) * vn - m * vo;
    wn  = clamp32((acc + 64'sd32768) >>> FRAC_W);
    velocity_mem[idx % ELEMENTS] = vn[VAL_W-1:0];
    r.idx      = idx;
    r.weight   = wn[VAL_W-1:0];
    r.velocity = vn[VAL_W-1:0];
    return r;
  endfunction

  // present one transaction, hold it until accepted, record its expected update;
  // tvalid stays high on exit so a zero gap gives back-to-back transactions
  task automatic send_update(input logic [IDX_W-1:0] idx,
                             input logic signed [VAL_W-1:0] w,
                             input logic signed [VAL_W-1:0] g);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'({g, w, idx});
    do @(posedge clk); while (!in_tready);
    pending_updates.push_back(nesterov_step(idx, w, g));
    last_idx = idx;
    @(negedge clk);
  endtask

  // stop sending and let every expected update come out
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_STEP_RATE) begin
      rate_q16 = val;
    end else begin
      mom_q16 = val;
    end
  endtask

  task automatic set_coefs(input logic [COEF_W-1:0] rate, input logic [COEF_W-1:0] mom);
    cfg_write(CFG_STEP_RATE, rate);
    cfg_write(CFG_MOMENTUM, mom);
  endtask

  // reset coefficients; field extremes and a repeated index right after itself
  task automatic test_reset_coefs;
    send_update(10'd0, 32'sd0, 32'sd65536);
    send_update(10'd0, 32'sd0, 32'sd65536);
    send_update(10'd1023, 32'sh7fffffff, 32'sh80000000);
    send_update(10'd1023, 32'sh80000000, 32'sh7fffffff);
    drain();
  endtask

  // zero rate: only the momentum term moves the velocity
  task automatic test_zero_rate;
    set_coefs(16'd0, MOMENTUM_RST);
    send_update(10'd0, 32'sh12345678, 32'sh7fffffff);
    send_update(10'd1023, -32'sd65536, 32'sh80000000);
    send_update(10'd0, 32'sd0, 32'sh55555555);
    drain();
  endtask

  // full rate and momentum with extreme gradients drive both formulas to saturation
  task automatic test_saturation;
    set_coefs(16'hffff, 16'hffff);
    repeat (4) send_update(10'd5, 32'sh7fffffff, 32'sh80000000);
    repeat (4) send_update(10'd6, 32'sh80000000, 32'sh7fffffff);
    send_update(10'd5, 32'sh80000000, 32'sh80000000);
    drain();
  endtask

  // no momentum and the smallest rate: pure gradient step, velocity history dropped
  task automatic test_no_momentum;
    set_coefs(16'd1, 16'd0);
    send_update(10'd5, 32'sh00010000, 32'sh7fffffff);
    send_update(10'd6, 32'shfffeffff, 32'sh80000000);
    send_update(10'd6, 32'sh7fffffff, -32'sd1);
    drain();
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(input int kind);
    case (kind)
      0, 1, 2, 3: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      4, 5:       return $urandom;
      6:          return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default:    return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  // random traffic over several coefficient settings; most transactions revisit a
  // small hot set of elements so velocities build up across many updates
  task automatic test_random_traffic;
    logic [IDX_W-1:0] hot_base, idx;
    int sel;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_coefs(COEF_W'($urandom_range(1, 65535)), COEF_W'($urandom_range(0, 65535)));
        1: set_coefs(COEF_W'($urandom_range(1, 2000)), COEF_W'($urandom_range(60000, 65535)));
        2: set_coefs(16'hffff, 16'hffff);
        default: set_coefs(STEP_RATE_RST, MOMENTUM_RST);
      endcase
      hot_base = IDX_W'($urandom_range(0, ELEMENTS - 8));
      for (int n = 0; n < 335; n++) begin
        if (n % 40 == 0) begin
          src_quiet  = ($urandom_range(0, 3) == 0);
          sink_quiet = ($urandom_range(0, 3) == 0);
        end
        // now and then hold off until the pipeline is empty
        if ($urandom_range(0, 149) == 0) drain();
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          idx = hot_base + IDX_W'($urandom_range(0, 7));
        end else if (sel == 6) begin
          idx = last_idx;
        end else begin
          idx = IDX_W'($urandom_range(0, ELEMENTS - 1));
        end
        send_update(idx, pick_value($urandom_range(0, 9)), pick_value($urandom_range(0, 7)));
      end
      src_quiet  = 1'b0;
      sink_quiet = 1'b0;
      drain();
    end
  endtask

  // result sink with its own random stalls
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = sink_quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // compare every result transaction against the oldest predicted update
  always @(posedge clk) begin
    update_t want;
    logic [IDX_W-1:0]        got_idx;
    logic signed [VAL_W-1:0] got_w, got_v;
    if (rst_n && out_tvalid && out_tready) begin
      got_idx = out_tdata[IDX_LO +: IDX_W];
      got_w   = out_tdata[WGT_LO +: VAL_W];
      got_v   = out_tdata[SEC_LO +: VAL_W];
      if (pending_updates.size() == 0) begin
        $display("%0t: result expected none actual idx=%0d weight=%0d velocity=%0d",
                 $time, got_idx, got_w, got_v);
        fail_count++;
      end else begin
        want = pending_updates.pop_front();
        if (got_idx !== want.idx) begin
          $display("%0t: element index expected %0d actual %0d", $time, want.idx, got_idx);
          fail_count++;
        end
        if (got_w !== want.weight) begin
          $display("%0t: weight of element %0d expected %0d actual %0d",
                   $time, want.idx, want.weight, got_w);
          fail_count++;
        end
        if (got_v !== want.velocity) begin
          $display("%0t: velocity of element %0d expected %0d actual %0d",
                   $time, want.idx, want.velocity, got_v);
          fail_count++;
        end
      end
    end
  end

  // sequence: reset, directed checks, random traffic, final verdict
  initial begin
    for (int i = 0; i < ELEMENTS; i++) velocity_mem[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the block clears its velocity memory first; send_update simply waits on tready
    test_reset_coefs();
    test_zero_rate();
    test_saturation();
    test_no_momentum();
    test_random_traffic();
    drain();
    if (pending_updates.size() == 0 && fail_count == 0) begin
      $display("[nesterov_momentum_update_top] OK");
    end else begin
      $display("[nesterov_momentum_update_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== nesterov_momentum_update_top.f =====
hw/rtl/nmu_pkg.sv
hw/rtl/nmu_ram.sv
hw/rtl/nmu_update_pipe.sv
hw/rtl/nmu_out_fifo.sv
hw/rtl/nesterov_momentum_update_top.sv
hw/rtl/nmu_checker.sv
bench/nesterov_momentum_update_top_tb.sv
